[rtl/core/usb_ep0_control_sequencer_unit_assert.svh]
// Assertion macros shared by the endpoint-0 sequencer modules.
// Each macro expects aclk and aresetn in the scope where it is used.
`ifndef USB_EP0_CONTROL_SEQUENCER_UNIT_ASSERT_SVH
`define USB_EP0_CONTROL_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define UE0CS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define UE0CS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ue0cs_pkg.sv]
package ue0cs_pkg;

    localparam int unsigned BUFFER_SIZE = 4096;
    localparam int unsigned LEN_W       = 13;
    localparam int unsigned MAX_CMDS    = 4;

    localparam logic EP_OUT = 1'b0;
    localparam logic EP_IN  = 1'b1;

    localparam logic [LEN_W-1:0] SETUP_LEN = LEN_W'(8);

    typedef enum logic [2:0] {
        REQ_RESET    = 3'd0,
        REQ_START    = 3'd1,
        REQ_NRDY     = 3'd2,
        REQ_COMPLETE = 3'd3,
        REQ_SEND     = 3'd4,
        REQ_RECV     = 3'd5,
        REQ_ACK      = 3'd6
    } req_t;

    typedef enum logic [2:0] {
        ST_NONE           = 3'd0,
        ST_SETUP_QUEUED   = 3'd1,
        ST_SETUP_RECEIVED = 3'd2,
        ST_DATA_OUT       = 3'd3,
        ST_DATA_IN        = 3'd4,
        ST_WAIT_NRDY_OUT  = 3'd5,
        ST_WAIT_NRDY_IN   = 3'd6,
        ST_STATUS         = 3'd7
    } state_t;

    typedef enum logic [2:0] {
        CMD_NEW_CONFIG = 3'd0,
        CMD_SET_CONFIG = 3'd1,
        CMD_END_XFER   = 3'd2,
        CMD_STALL      = 3'd3,
        CMD_START      = 3'd4,
        CMD_NOTICE     = 3'd5,
        CMD_REJECT     = 3'd6
    } cmd_code_t;

    typedef enum logic [1:0] {
        TRB_SETUP   = 2'd0,
        TRB_DATA    = 2'd1,
        TRB_STATUS2 = 2'd2,
        TRB_STATUS3 = 2'd3
    } trb_kind_t;

    typedef struct packed {
        cmd_code_t        cmd;
        logic             ep;
        trb_kind_t        kind;
        logic [LEN_W-1:0] len;
    } cmd_t;

    // Decoded command list for one event; cnt runs from 0 to MAX_CMDS.
    typedef struct packed {
        logic [2:0]  cnt;
        cmd_t [3:0]  cmds;
    } cmd_list_t;

    function automatic cmd_t mk_cmd(input cmd_code_t c, input logic ep,
                                    input trb_kind_t k, input logic [LEN_W-1:0] len);
        cmd_t r;
        r.cmd  = c;
        r.ep   = ep;
        r.kind = k;
        r.len  = len;
        return r;
    endfunction

endpackage

[rtl/core/usb_ep0_control_sequencer_unit.sv]
// An event word is registered on acceptance, decoded from the event register and loaded into the
// command buffer once the buffer is free; its first command word is then driven from the buffer.
// Throughput: an event producing 1 to 4 command words sends them in order, holding while m_tready is low;
// events with no commands pass at one per cycle, even while earlier command words drain.
// Reset (aresetn low, synchronous): stage state returns to none, data-stage flag clears,
// and both the event register and command buffer are emptied.
`include "usb_ep0_control_sequencer_unit_assert.svh"

module usb_ep0_control_sequencer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] ep_dir, [2:1] stage, [18:3] setup_length, [34:19] xfer_length, rest zero
    input  logic [39:0] s_tdata,
    // [2:0] req_type
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] cmd_ep, [2:1] trb_kind, [15:3] out_length, [18:16] state_after, rest zero
    output logic [23:0] m_tdata,
    // [2:0] cmd
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    logic              in_valid_reg, in_valid_next;
    logic [2:0]        req_reg;
    logic              ep_dir_reg;
    logic [1:0]        stage_reg;
    logic [15:0]       setup_len_reg;
    logic [15:0]       xfer_len_reg;

    ue0cs_pkg::state_t state_reg, state_next;
    logic              has_data_reg, has_data_next;

    ue0cs_pkg::cmd_list_t dec_list;
    ue0cs_pkg::cmd_t      q_cmd;
    ue0cs_pkg::state_t    q_state;
    logic                 q_free;
    logic                 advance;
    logic                 load;

    ue0cs_decode u_decode (
        .req           (req_reg),
        .ep_dir        (ep_dir_reg),
        .stage         (stage_reg),
        .setup_length  (setup_len_reg),
        .xfer_length   (xfer_len_reg),
        .state_cur     (state_reg),
        .has_data_cur  (has_data_reg),
        .state_next    (state_next),
        .has_data_next (has_data_next),
        .cmd_list      (dec_list)
    );

    // Events with no commands retire even while earlier words are still draining.
    assign advance  = in_valid_reg && ((dec_list.cnt == 3'd0) || q_free);
    assign load     = in_valid_reg && (dec_list.cnt != 3'd0) && q_free;
    assign s_tready = !in_valid_reg || advance;

    ue0cs_cmd_queue u_cmd_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .load_list  (dec_list),
        .load_state (state_next),
        .free       (q_free),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_cmd    (q_cmd),
        .out_state  (q_state),
        .out_last   (m_tlast)
    );

    assign m_tuser = q_cmd.cmd;
    assign m_tdata = {5'd0, q_state, q_cmd.len, q_cmd.kind, q_cmd.ep};

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= ue0cs_pkg::ST_NONE;
            has_data_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (advance) begin
                state_reg    <= state_next;
                has_data_reg <= has_data_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg       <= s_tuser;
            ep_dir_reg    <= s_tdata[0];
            stage_reg     <= s_tdata[2:1];
            setup_len_reg <= s_tdata[18:3];
            xfer_len_reg  <= s_tdata[34:19];
        end
    end

    `UE0CS_ASSERT_NEXT(a_reject_keeps_state, advance && dec_list.cnt == 3'd1 && dec_list.cmds[0].cmd == ue0cs_pkg::CMD_REJECT, $stable(state_reg) && $stable(has_data_reg), "rejection changed stage state")
    `UE0CS_ASSERT_NEXT(a_start_queues_setup, advance && req_reg == ue0cs_pkg::REQ_START, state_reg == ue0cs_pkg::ST_SETUP_QUEUED, "start did not queue setup")
    `UE0CS_ASSERT_NEXT(a_flag_only_on_complete, advance && req_reg != ue0cs_pkg::REQ_COMPLETE, $stable(has_data_reg), "data-stage flag changed outside completion")

endmodule

[rtl/core/ue0cs_decode.sv]
module ue0cs_decode (
    input  logic [2:0]              req,
    input  logic                    ep_dir,
    input  logic [1:0]              stage,
    input  logic [15:0]             setup_length,
    input  logic [15:0]             xfer_length,
    input  ue0cs_pkg::state_t       state_cur,
    input  logic                    has_data_cur,
    output ue0cs_pkg::state_t       state_next,
    output logic                    has_data_next,
    output ue0cs_pkg::cmd_list_t    cmd_list
);

    logic                 stg_data_or_status;
    logic                 stg_data;
    logic                 send_bad;
    ue0cs_pkg::cmd_t      setup_cmd;
    ue0cs_pkg::trb_kind_t status_kind;

    assign stg_data_or_status = (stage == 2'd1) || (stage == 2'd2);
    assign stg_data           = (stage == 2'd1);
    assign send_bad = (state_cur != ue0cs_pkg::ST_SETUP_RECEIVED) ||
                      (xfer_length > 16'(ue0cs_pkg::BUFFER_SIZE));
    assign setup_cmd = ue0cs_pkg::mk_cmd(ue0cs_pkg::CMD_START, ue0cs_pkg::EP_OUT,
                                         ue0cs_pkg::TRB_SETUP, ue0cs_pkg::SETUP_LEN);
    assign status_kind = has_data_cur ? ue0cs_pkg::TRB_STATUS3 : ue0cs_pkg::TRB_STATUS2;

    // Next stage state.
    always_comb begin
        state_next    = state_cur;
        has_data_next = has_data_cur;
        case (req)
            ue0cs_pkg::REQ_RESET: begin
                state_next = ue0cs_pkg::ST_NONE;
            end
            ue0cs_pkg::REQ_START: begin
                state_next = ue0cs_pkg::ST_SETUP_QUEUED;
            end
            ue0cs_pkg::REQ_NRDY: begin
                case (state_cur)
                    ue0cs_pkg::ST_SETUP_QUEUED: begin
                        if (stg_data_or_status) state_next = ue0cs_pkg::ST_SETUP_QUEUED;
                    end
                    ue0cs_pkg::ST_DATA_OUT: begin
                        if (ep_dir == ue0cs_pkg::EP_IN && stg_data)
                            state_next = ue0cs_pkg::ST_SETUP_QUEUED;
                    end
                    ue0cs_pkg::ST_DATA_IN: begin
                        if (ep_dir == ue0cs_pkg::EP_OUT && stg_data)
                            state_next = ue0cs_pkg::ST_SETUP_QUEUED;
                    end
                    ue0cs_pkg::ST_WAIT_NRDY_OUT: begin
                        if (ep_dir == ue0cs_pkg::EP_OUT) state_next = ue0cs_pkg::ST_STATUS;
                    end
                    ue0cs_pkg::ST_WAIT_NRDY_IN: begin
                        if (ep_dir == ue0cs_pkg::EP_IN) state_next = ue0cs_pkg::ST_STATUS;
                    end
                    default: begin
                        state_next = state_cur;
                    end
                endcase
            end
            ue0cs_pkg::REQ_COMPLETE: begin
                case (state_cur)
                    ue0cs_pkg::ST_SETUP_QUEUED: begin
                        has_data_next = (setup_length != 16'd0);
                        state_next    = ue0cs_pkg::ST_SETUP_RECEIVED;
                    end
                    ue0cs_pkg::ST_DATA_OUT: state_next = ue0cs_pkg::ST_WAIT_NRDY_IN;
                    ue0cs_pkg::ST_DATA_IN:  state_next = ue0cs_pkg::ST_WAIT_NRDY_OUT;
                    ue0cs_pkg::ST_STATUS:   state_next = ue0cs_pkg::ST_SETUP_QUEUED;
                    default:                state_next = state_cur;
                endcase
            end
            ue0cs_pkg::REQ_SEND: begin
                if (!send_bad) state_next = ue0cs_pkg::ST_DATA_IN;
            end
            ue0cs_pkg::REQ_RECV: begin
                if (!send_bad) state_next = ue0cs_pkg::ST_DATA_OUT;
            end
            ue0cs_pkg::REQ_ACK: begin
                if (state_cur == ue0cs_pkg::ST_SETUP_RECEIVED && !has_data_cur)
                    state_next = ue0cs_pkg::ST_WAIT_NRDY_IN;
            end
            default: begin
                state_next = state_cur;
            end
        endcase
    end

    // Commands emitted for the event, in order.
    always_comb begin
        cmd_list = '0;
        case (req)
            ue0cs_pkg::REQ_RESET: begin
                cmd_list.cnt     = 3'd1;
                cmd_list.cmds[0] = ue0cs_pkg::mk_cmd(ue0cs_pkg::CMD_END_XFER,
                    ue0cs_pkg::EP_OUT, ue0cs_pkg::TRB_SETUP, '0);
            end
            ue0cs_pkg::REQ_START: begin
                cmd_list.cnt     = 3'd4;
                cmd_list.cmds[0] = ue0cs_pkg::mk_cmd(ue0cs_pkg::CMD_NEW_CONFIG,
                    ue0cs_pkg::EP_OUT, ue0cs_pkg::TRB_SETUP, '0);
                cmd_list.cmds[1] = ue0cs_pkg::mk_cmd(ue0cs_pkg::CMD_SET_CONFIG,
                    ue0cs_pkg::EP_OUT, ue0cs_pkg::TRB_SETUP, '0);
                cmd_list.cmds[2] = ue0cs_pkg::mk_cmd(ue0cs_pkg::CMD_SET_CONFIG,
                    ue0cs_pkg::EP_IN, ue0cs_pkg::TRB_SETUP, '0);
                cmd_list.cmds[3] = setup_cmd;
            end
            ue0cs_pkg::REQ_NRDY: begin
                case (state_cur)
                    ue0cs_pkg::ST_SETUP_QUEUED: begin
                        if (stg_data_or_status) begin
                            cmd_list.cnt     = 3'd2;
                            cmd_list.cmds[0] = ue0cs_pkg::mk_cmd(ue0cs_pkg::CMD_STALL,
                                ue0cs_pkg::EP_OUT, ue0cs_pkg::TRB_SETUP, '0);
                            cmd_list.cmds[1] = setup_cmd;
                        end
                    end
                    ue0cs_pkg::ST_DATA_OUT, ue0cs_pkg::ST_DATA_IN: begin
                        // A not-ready on the opposite endpoint during the data stage
                        // aborts the transfer and stalls.
                        if (stg_data && (ep_dir == (state_cur == ue0cs_pkg::ST_DATA_OUT)))
                        begin
                            cmd_list.cnt     = 3'd3;
                            cmd_list.cmds[0] = ue0cs_pkg::mk_cmd(ue0cs_pkg::CMD_END_XFER,
                                (state_cur == ue0cs_pkg::ST_DATA_IN),
                                ue0cs_pkg::TRB_SETUP, '0);
                            cmd_list.cmds[1] = ue0cs_pkg::mk_cmd(ue0cs_pkg::CMD_STALL,
                                ue0cs_pkg::EP_OUT, ue0cs_pkg::TRB_SETUP, '0);
                            cmd_list.cmds[2] = setup_cmd;
                        end
                    end
                    ue0cs_pkg::ST_WAIT_NRDY_OUT, ue0cs_pkg::ST_WAIT_NRDY_IN: begin
                        if (ep_dir == (state_cur == ue0cs_pkg::ST_WAIT_NRDY_IN)) begin
                            cmd_list.cnt     = 3'd1;
                            cmd_list.cmds[0] = ue0cs_pkg::mk_cmd(ue0cs_pkg::CMD_START,
                                ep_dir, status_kind, '0);
                        end
                    end
                    default: begin
                        cmd_list.cnt = 3'd0;
                    end
                endcase
            end
            ue0cs_pkg::REQ_COMPLETE: begin
                if (state_cur == ue0cs_pkg::ST_SETUP_QUEUED) begin
                    cmd_list.cnt     = 3'd1;
                    cmd_list.cmds[0] = ue0cs_pkg::mk_cmd(ue0cs_pkg::CMD_NOTICE,
                        1'b0, ue0cs_pkg::TRB_SETUP, '0);
                end else if (state_cur == ue0cs_pkg::ST_STATUS) begin
                    cmd_list.cnt     = 3'd1;
                    cmd_list.cmds[0] = setup_cmd;
                end
            end
            ue0cs_pkg::REQ_SEND, ue0cs_pkg::REQ_RECV: begin
                cmd_list.cnt = 3'd1;
                if (send_bad) begin
                    cmd_list.cmds[0] = ue0cs_pkg::mk_cmd(ue0cs_pkg::CMD_REJECT,
                        1'b0, ue0cs_pkg::TRB_SETUP, '0);
                end else begin
                    cmd_list.cmds[0] = ue0cs_pkg::mk_cmd(ue0cs_pkg::CMD_START,
                        (req == ue0cs_pkg::REQ_SEND), ue0cs_pkg::TRB_DATA,
                        xfer_length[ue0cs_pkg::LEN_W-1:0]);
                end
            end
            ue0cs_pkg::REQ_ACK: begin
                if (state_cur != ue0cs_pkg::ST_SETUP_RECEIVED) begin
                    cmd_list.cnt     = 3'd1;
                    cmd_list.cmds[0] = ue0cs_pkg::mk_cmd(ue0cs_pkg::CMD_REJECT,
                        1'b0, ue0cs_pkg::TRB_SETUP, '0);
                end
            end
            default: begin
                cmd_list.cnt = 3'd0;
            end
        endcase
    end

endmodule

[rtl/core/ue0cs_cmd_queue.sv]
`include "usb_ep0_control_sequencer_unit_assert.svh"

module ue0cs_cmd_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load,
    input  ue0cs_pkg::cmd_list_t    load_list,
    input  ue0cs_pkg::state_t       load_state,
    output logic                    free,
    input  logic                    out_ready,
    output logic                    out_valid,
    output ue0cs_pkg::cmd_t         out_cmd,
    output ue0cs_pkg::state_t       out_state,
    output logic                    out_last
);

    logic                  valid_reg, valid_next;
    logic [1:0]            idx_reg, idx_next;
    logic [1:0]            last_reg, last_next;
    ue0cs_pkg::cmd_t [3:0] cmds_reg;
    ue0cs_pkg::state_t     state_reg;

    assign out_valid = valid_reg;
    assign out_last  = (idx_reg == last_reg);
    assign out_cmd   = cmds_reg[idx_reg];
    assign out_state = state_reg;
    // The buffer can take a new list when empty or when its final word leaves now.
    assign free      = !valid_reg || (out_ready && out_last);

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
            last_next  = 2'(load_list.cnt - 3'd1);
        end else if (valid_reg && out_ready) begin
            if (out_last) begin
                valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
            last_reg  <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cmds_reg  <= load_list.cmds;
            state_reg <= load_state;
        end
    end

    `UE0CS_ASSERT_NOW(a_idx_in_range, valid_reg, idx_reg <= last_reg, "word index past end of list")
    `UE0CS_ASSERT_NOW(a_no_overwrite, valid_reg && !out_ready, !load, "list loaded over pending words")
    `UE0CS_ASSERT_NEXT(a_drain_empties, valid_reg && out_ready && out_last && !load, !valid_reg, "buffer not empty after final word")

endmodule
